@@ rtl/sha_pkg.sv @@
// Package: SHA-256 constants, command/status types and a rotate function.
`timescale 1ns / 1ps
package sha_pkg;

   localparam logic [31:0] H_INIT [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   localparam logic [31:0] K_ROUND [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

   localparam logic [7:0] PAD_BYTE = 8'h80;
   localparam logic [5:0] LEN_POS  = 6'd56;

   // Byte source selects for the chunk loader
   localparam logic [1:0] SRC_DATA = 2'd0;
   localparam logic [1:0] SRC_PAD  = 2'd1;
   localparam logic [1:0] SRC_ZERO = 2'd2;
   localparam logic [1:0] SRC_LEN  = 2'd3;

   typedef struct packed {
      logic       put_byte;   // write one byte into the chunk
      logic [1:0] byte_src;
      logic       add_len;    // count one message byte
      logic       snap_len;   // freeze length for the trailer
      logic       comp_start; // load a..h from chain
      logic       round_en;   // one compression round
      logic       comp_done;  // add a..h into chain
      logic       clear;      // back to reset state
   } cmd_type;

   typedef struct packed {
      logic       chunk_full;  // next put fills the chunk
      logic [5:0] byte_pos;
      logic       rounds_done; // round 63 in progress
   } status_type;

   function automatic logic [31:0] ror(input logic [31:0] v, input int k);
      ror = (v >> k) | (v << (32 - k));
   endfunction

endpackage

@@ rtl/sha_datapath.sv @@
// Datapath: chunk buffer, message schedule, round logic, chain and length.
`timescale 1ns / 1ps
module sha_datapath (
   input  logic                    clock,
   input  logic                    reset,
   input  sha_pkg::cmd_type        cmd,
   input  logic [7:0]              data_byte,
   input  logic [2:0]              len_sel,
   input  logic [2:0]              out_sel,
   output sha_pkg::status_type     status,
   output logic [31:0]             out_word
);
   logic [31:0] chunk_ff [16];
   logic [31:0] sched_ff [16];
   logic [31:0] chain_ff [8];
   logic [31:0] var_ff [8];
   logic [63:0] bitlen_ff;
   logic [63:0] lensnap_ff;
   logic [5:0]  pos_ff;
   logic [5:0]  round_ff;

   logic [7:0]  put_val;
   logic [31:0] w_in, s0w, s1w, w15, w2;
   logic [31:0] e_s1, a_s0, ch, mj, t1, t2;
   logic [3:0]  rslot;

   // Select the byte to load
   always_comb begin
      case (cmd.byte_src)
         sha_pkg::SRC_DATA: put_val = data_byte;
         sha_pkg::SRC_PAD:  put_val = sha_pkg::PAD_BYTE;
         sha_pkg::SRC_ZERO: put_val = 8'h00;
         default:           put_val = lensnap_ff[{3'd7 - len_sel, 3'd0} +: 8];
      endcase
   end

   // Schedule word for this round
   assign rslot = round_ff[3:0];
   assign w15   = sched_ff[rslot + 4'd1];
   assign w2    = sched_ff[rslot + 4'd14];
   assign s0w   = sha_pkg::ror(w15, 7) ^ sha_pkg::ror(w15, 18) ^ (w15 >> 3);
   assign s1w   = sha_pkg::ror(w2, 17) ^ sha_pkg::ror(w2, 19) ^ (w2 >> 10);
   assign w_in  = (round_ff < 6'd16) ? chunk_ff[rslot]
                : sched_ff[rslot] + s0w + sched_ff[rslot + 4'd9] + s1w;

   assign e_s1 = sha_pkg::ror(var_ff[4], 6) ^ sha_pkg::ror(var_ff[4], 11)
               ^ sha_pkg::ror(var_ff[4], 25);
   assign ch   = (var_ff[4] & var_ff[5]) ^ (~var_ff[4] & var_ff[6]);
   assign t1   = var_ff[7] + e_s1 + ch + sha_pkg::K_ROUND[round_ff] + w_in;
   assign a_s0 = sha_pkg::ror(var_ff[0], 2) ^ sha_pkg::ror(var_ff[0], 13)
               ^ sha_pkg::ror(var_ff[0], 22);
   assign mj   = (var_ff[0] & var_ff[1]) ^ (var_ff[0] & var_ff[2]) ^ (var_ff[1] & var_ff[2]);
   assign t2   = a_s0 + mj;

   // Chunk buffer and byte slot
   always_ff @(posedge clock) begin
      if (cmd.put_byte) begin
         if (pos_ff[1:0] == 2'd0) begin
            chunk_ff[pos_ff[5:2]] <= {put_val, 24'h0};
         end else begin
            chunk_ff[pos_ff[5:2]][{2'd3 - pos_ff[1:0], 3'd0} +: 8] <= put_val;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         pos_ff    <= '0;
         bitlen_ff <= '0;
         round_ff  <= '0;
         for (int i = 0; i < 8; i++) begin
            chain_ff[i] <= sha_pkg::H_INIT[i];
            var_ff[i]   <= '0;
         end
      end else begin
         if (cmd.put_byte) pos_ff <= pos_ff + 6'd1;
         if (cmd.add_len) bitlen_ff <= bitlen_ff + 64'd8;
         if (cmd.comp_start) begin
            round_ff <= '0;
            for (int i = 0; i < 8; i++) var_ff[i] <= chain_ff[i];
         end else if (cmd.round_en) begin
            round_ff <= round_ff + 6'd1;
            var_ff[7] <= var_ff[6];
            var_ff[6] <= var_ff[5];
            var_ff[5] <= var_ff[4];
            var_ff[4] <= var_ff[3] + t1;
            var_ff[3] <= var_ff[2];
            var_ff[2] <= var_ff[1];
            var_ff[1] <= var_ff[0];
            var_ff[0] <= t1 + t2;
         end
         if (cmd.comp_done) begin
            for (int i = 0; i < 8; i++) chain_ff[i] <= chain_ff[i] + var_ff[i];
         end
      end
   end

   // Schedule ring and length snapshot
   always_ff @(posedge clock) begin
      if (cmd.round_en) sched_ff[rslot] <= w_in;
      if (cmd.snap_len) lensnap_ff <= bitlen_ff;
   end

   assign status.chunk_full  = (pos_ff == 6'd63);
   assign status.byte_pos    = pos_ff;
   assign status.rounds_done = (round_ff == 6'd63);
   assign out_word           = chain_ff[out_sel];
endmodule

@@ rtl/sha_control.sv @@
// Controller: handshake, padding sequence, round count and digest output.
`timescale 1ns / 1ps
module sha_control (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_byte_present,
   input  logic                req_last_item,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [2:0]          rsp_word_index,
   output logic                rsp_last_word,
   output sha_pkg::cmd_type    cmd,
   input  sha_pkg::status_type status,
   output logic [2:0]          len_sel
);
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_PAD  = 3'd1;
   localparam logic [2:0] ST_ZERO = 3'd2;
   localparam logic [2:0] ST_LEN  = 3'd3;
   localparam logic [2:0] ST_COMP = 3'd4;
   localparam logic [2:0] ST_OUT  = 3'd5;

   logic [2:0] state_ff, state_in;
   logic [2:0] ret_ff, ret_in;       // state after compression
   logic       fin_ff, fin_in;       // finishing the message
   logic       startc_ff, startc_in; // compression load cycle
   logic [2:0] cnt_ff, cnt_in;
   logic       take;

   assign req_ready = (state_ff == ST_IDLE) && !startc_ff;
   assign take      = req_valid && req_ready;
   assign rsp_valid = (state_ff == ST_OUT);
   assign rsp_word_index = cnt_ff;
   assign rsp_last_word  = (cnt_ff == 3'd7);
   assign len_sel        = cnt_ff;

   // Sequence bytes, rounds and outputs
   always_comb begin
      state_in  = state_ff;
      ret_in    = ret_ff;
      fin_in    = fin_ff;
      startc_in = 1'b0;
      cnt_in    = cnt_ff;
      cmd       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (startc_ff) begin
               cmd.comp_start = 1'b1;
               state_in       = ST_COMP;
            end else if (take) begin
               cmd.byte_src = sha_pkg::SRC_DATA;
               cmd.put_byte = req_byte_present;
               cmd.add_len  = req_byte_present;
               fin_in       = req_last_item;
               if (req_byte_present && status.chunk_full) begin
                  startc_in = 1'b1;
                  ret_in    = req_last_item ? ST_PAD : ST_IDLE;
               end else if (req_last_item) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            // Length is final here: freeze it for the trailer
            cmd.put_byte = 1'b1;
            cmd.byte_src = sha_pkg::SRC_PAD;
            cmd.snap_len = 1'b1;
            if (status.chunk_full) begin
               startc_in = 1'b1;
               ret_in    = ST_ZERO;
               state_in  = ST_IDLE;
            end else begin
               state_in = ST_ZERO;
            end
         end
         ST_ZERO: begin
            if (status.byte_pos == sha_pkg::LEN_POS) begin
               cnt_in   = '0;
               state_in = ST_LEN;
            end else begin
               cmd.put_byte = 1'b1;
               cmd.byte_src = sha_pkg::SRC_ZERO;
               if (status.chunk_full) begin
                  startc_in = 1'b1;
                  ret_in    = ST_ZERO;
                  state_in  = ST_IDLE;
               end
            end
         end
         ST_LEN: begin
            cmd.put_byte = 1'b1;
            cmd.byte_src = sha_pkg::SRC_LEN;
            cnt_in       = cnt_ff + 3'd1;
            if (cnt_ff == 3'd7) begin
               startc_in = 1'b1;
               ret_in    = ST_OUT;
               state_in  = ST_IDLE;
            end
         end
         ST_COMP: begin
            cmd.round_en = 1'b1;
            if (status.rounds_done) begin
               state_in = ST_IDLE;
               fin_in   = fin_ff;
            end
         end
         ST_OUT: begin
            if (rsp_ready) begin
               cnt_in = cnt_ff + 3'd1;
               if (cnt_ff == 3'd7) begin
                  cmd.clear = 1'b1;
                  fin_in    = 1'b0;
                  state_in  = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
      // Fold chain after the final round, then resume
      if (state_ff == ST_COMP && status.rounds_done) begin
         state_in = ret_ff;
         if (ret_ff == ST_OUT) cnt_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         ret_ff    <= ST_IDLE;
         fin_ff    <= 1'b0;
         startc_ff <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         ret_ff    <= ret_in;
         fin_ff    <= fin_in;
         startc_ff <= startc_in;
         cnt_ff    <= cnt_in;
      end
   end
endmodule

@@ rtl/sha256_stream_hasher.sv @@
// Top level: SHA-256 byte stream hasher.
`timescale 1ns / 1ps
// One message byte per transfer; a transfer with last_item set pads the
// message and returns the eight digest words, index 0 first. Each filled
// 64-byte chunk is compressed by a load, 64 rounds on one shared round unit
// and a chain add, and input is stalled while that runs. Finishing adds
// the padding bytes, one or two chunk compressions and eight output
// transfers.
module sha256_stream_hasher (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_byte_present,
   input  logic        req_last_item,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last_word
);
   sha_pkg::cmd_type    ctl_cmd, dp_cmd;
   sha_pkg::status_type dp_status;
   logic [2:0]          len_sel;
   logic                fold_ff;
   logic                hold_ready;
   logic                ctl_rsp_valid;

   // Chain add is registered and follows in the cycle after the final round
   always_ff @(posedge clock) begin
      if (reset) begin
         fold_ff <= 1'b0;
      end else begin
         fold_ff <= ctl_cmd.round_en && dp_status.rounds_done;
      end
   end

   always_comb begin
      dp_cmd           = ctl_cmd;
      dp_cmd.comp_done = fold_ff;
   end

   sha_control u_ctl (
      .clock(clock), .reset(reset),
      .req_valid(req_valid && !fold_ff), .req_ready(hold_ready),
      .req_byte_present(req_byte_present), .req_last_item(req_last_item),
      .rsp_valid(ctl_rsp_valid), .rsp_ready(rsp_ready && !fold_ff),
      .rsp_word_index(rsp_word_index), .rsp_last_word(rsp_last_word),
      .cmd(ctl_cmd), .status(dp_status), .len_sel(len_sel));

   assign req_ready = hold_ready && !fold_ff;
   // Hold the digest until the chain add lands
   assign rsp_valid = ctl_rsp_valid && !fold_ff;

   sha_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(dp_cmd),
      .data_byte(req_data_byte), .len_sel(len_sel), .out_sel(rsp_word_index),
      .status(dp_status), .out_word(rsp_digest_word));

`ifndef SYNTH
   // Never take input while a digest is pending
   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> !req_ready)
      else $error("input taken during digest output");
   // Last digest word sits at index seven
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_word |-> rsp_word_index == 3'd7)
      else $error("last word flag misplaced");
   // Chain add never overlaps a round
   assert property (@(posedge clock) disable iff (reset) fold_ff |-> !ctl_cmd.round_en)
      else $error("chain add during round");
`endif
endmodule
